### rtl/core/p1ts_pkg.sv
`timescale 1ns / 1ps

package p1ts_pkg;

  localparam int TAG_W   = 32;
  localparam int CRD_W   = 32;
  localparam int EDGE_W  = CRD_W + 1;         // exact vertex difference
  localparam int PROD_W  = 2 * EDGE_W;        // exact product, Q18.48
  localparam int SUM_W   = PROD_W + 1;        // det and numerators
  localparam int FRAC_W  = 24;
  localparam int OUT_W   = 48;
  localparam int QW      = OUT_W;             // quotient bits before clamping
  localparam int DEN_W   = SUM_W;             // 2*|det| < 2^67
  localparam int NUM_W   = SUM_W + FRAC_W;    // |N|*2^24 + |det| < 2^91
  localparam int HI_W    = NUM_W - QW;
  localparam int AREA_W  = SUM_W + 1 - (FRAC_W + 1);
  localparam int N_ENT   = 6;
  localparam int DIV_LAT = QW + 1;

  localparam logic [OUT_W-1:0] ENT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] ENT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic        [TAG_W-1:0] cell_tag;
    logic signed [CRD_W-1:0] x0;
    logic signed [CRD_W-1:0] y0;
    logic signed [CRD_W-1:0] x1;
    logic signed [CRD_W-1:0] y1;
    logic signed [CRD_W-1:0] x2;
    logic signed [CRD_W-1:0] y2;
  } in_t;

  typedef struct packed {
    logic        [TAG_W-1:0] tag_out;
    logic signed [OUT_W-1:0] k00;
    logic signed [OUT_W-1:0] k01;
    logic signed [OUT_W-1:0] k02;
    logic signed [OUT_W-1:0] k11;
    logic signed [OUT_W-1:0] k12;
    logic signed [OUT_W-1:0] k22;
    logic signed [OUT_W-1:0] area;
    logic                    degenerate;
  } out_t;

  // Apply sign to the quotient magnitude and clamp to 48 bits.
  function automatic logic [OUT_W-1:0] sat_entry(input logic ovf, input logic neg,
                                                 input logic [QW-1:0] q);
    logic [OUT_W-1:0] r;
    if (ovf) begin
      r = neg ? ENT_MIN : ENT_MAX;
    end else if (neg) begin
      r = (q > ENT_MIN) ? ENT_MIN : (~q + 1'b1);
    end else begin
      r = q[QW-1] ? ENT_MAX : q;
    end
    return r;
  endfunction

endpackage

### rtl/core/p1ts_if.sv
`timescale 1ns / 1ps

interface p1ts_in_if import p1ts_pkg::*; ();
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface p1ts_out_if import p1ts_pkg::*; ();
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/p1ts_div.sv
`timescale 1ns / 1ps

// Pipelined restoring divider: one overflow check stage, then one quotient bit a stage.
module p1ts_div import p1ts_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] numer_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QW-1:0]    q_o,
  output logic             ovf_o
);

  logic [DEN_W-1:0] r_q   [0:QW];
  logic [QW-1:0]    lo_q  [0:QW];
  logic [QW-1:0]    q_q   [0:QW];
  logic [DEN_W-1:0] den_q [0:QW];
  logic             ovf_q [0:QW];

  // quotient >= 2^48 exactly when the top part alone reaches the divisor
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= DEN_W'(numer_i[NUM_W-1:QW]) >= den_i;
      r_q[0]   <= DEN_W'(numer_i[NUM_W-1:QW]);
      lo_q[0]  <= numer_i[QW-1:0];
      q_q[0]   <= '0;
      den_q[0] <= den_i;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [DEN_W:0] sh;
    logic [DEN_W:0] diff;
    logic           ge;

    assign sh   = {r_q[k-1], lo_q[k-1][QW-1]};
    assign diff = sh - {1'b0, den_q[k-1]};
    assign ge   = sh >= {1'b0, den_q[k-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]   <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
        lo_q[k]  <= {lo_q[k-1][QW-2:0], 1'b0};
        q_q[k]   <= {q_q[k-1][QW-2:0], ge};
        den_q[k] <= den_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign q_o   = q_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

### rtl/core/p1_triangle_stiffness_unit.sv
`timescale 1ns / 1ps

// Linear triangle element stiffness unit.
// in_i  : one triangle per request, three vertices in signed Q8.24 and a tag.
// out_o : one result per triangle, in order: tag, six distinct entries of the
//         symmetric 3x3 stiffness matrix and the signed area, all signed Q24.24
//         and saturated, plus a degenerate flag (zero determinant, entries zero).
// From accepted request to valid result a request passes through five arithmetic
// stages (edges, 33x33 products, sums, magnitudes, dividend), a 49 stage
// divider per entry (overflow check plus one quotient bit per stage) and the
// output register.
// Throughput is one triangle per cycle; the whole pipeline moves in lockstep.
// When the receiver stalls with a result waiting, the pipeline freezes and
// in_i.ready drops; bubbles in the pipe are not squeezed out.
// Reset clears the valid bits only; the datapath carries no reset.
module p1_triangle_stiffness_unit import p1ts_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  p1ts_in_if.sink       in_i,
  p1ts_out_if.source    out_o
);

  logic adv;
  logic out_vld_q;
  out_t out_q;

  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  // stage 1: edge vectors
  logic                     v1_q;
  logic        [TAG_W-1:0]  tag1_q;
  logic signed [EDGE_W-1:0] ea_q, eb_q, ec_q, ed_q, ecd_q, eba_q;

  // stage 2: products
  logic                     v2_q;
  logic        [TAG_W-1:0]  tag2_q;
  logic signed [PROD_W-1:0] p_ad_q, p_bc_q, p_cdcd_q, p_baba_q, p_cdd_q, p_bab_q, p_baa_q;
  logic signed [PROD_W-1:0] p_cdc_q, p_dd_q, p_bb_q, p_dc_q, p_ba_q, p_cc_q, p_aa_q;

  // stage 3: determinant and numerators
  logic                     v3_q;
  logic        [TAG_W-1:0]  tag3_q;
  logic signed [SUM_W-1:0]  det_q;
  logic signed [SUM_W-1:0]  n_q [N_ENT];

  // stage 4: magnitudes and signs
  logic                     v4_q;
  logic        [TAG_W-1:0]  tag4_q;
  logic        [SUM_W-1:0]  nmag_q [N_ENT];
  logic        [SUM_W-1:0]  dmag_q;
  logic        [N_ENT-1:0]  neg4_q;
  logic                     deg4_q;
  logic        [AREA_W-1:0] area4_q;
  logic        [SUM_W:0]    area_rnd;

  // stage 5: dividends and divisor
  logic                     v5_q;
  logic        [TAG_W-1:0]  tag5_q;
  logic        [NUM_W-1:0]  numer_q [N_ENT];
  logic        [DEN_W-1:0]  den_q;
  logic        [N_ENT-1:0]  neg5_q;
  logic                     deg5_q;
  logic        [AREA_W-1:0] area5_q;

  // side band alongside the dividers
  logic                     vd_q    [DIV_LAT];
  logic        [TAG_W-1:0]  tagd_q  [DIV_LAT];
  logic        [N_ENT-1:0]  negd_q  [DIV_LAT];
  logic                     degd_q  [DIV_LAT];
  logic        [AREA_W-1:0] aread_q [DIV_LAT];

  logic        [QW-1:0]     quo   [N_ENT];
  logic        [N_ENT-1:0]  ovf;
  logic        [OUT_W-1:0]  ent   [N_ENT];

  assign area_rnd = (SUM_W + 1)'(det_q) + (SUM_W + 1)'(1 << FRAC_W);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < DIV_LAT; i++) vd_q[i] <= 1'b0;
    end else if (adv) begin
      v1_q      <= in_i.valid;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      vd_q[0]   <= v5_q;
      for (int i = 1; i < DIV_LAT; i++) vd_q[i] <= vd_q[i-1];
      out_vld_q <= vd_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tag1_q <= in_i.data.cell_tag;
      ea_q   <= EDGE_W'(in_i.data.x1) - EDGE_W'(in_i.data.x0);
      eb_q   <= EDGE_W'(in_i.data.x2) - EDGE_W'(in_i.data.x0);
      ec_q   <= EDGE_W'(in_i.data.y1) - EDGE_W'(in_i.data.y0);
      ed_q   <= EDGE_W'(in_i.data.y2) - EDGE_W'(in_i.data.y0);
      ecd_q  <= EDGE_W'(in_i.data.y1) - EDGE_W'(in_i.data.y2);
      eba_q  <= EDGE_W'(in_i.data.x2) - EDGE_W'(in_i.data.x1);

      tag2_q   <= tag1_q;
      p_ad_q   <= ea_q * ed_q;
      p_bc_q   <= eb_q * ec_q;
      p_cdcd_q <= ecd_q * ecd_q;
      p_baba_q <= eba_q * eba_q;
      p_cdd_q  <= ecd_q * ed_q;
      p_bab_q  <= eba_q * eb_q;
      p_baa_q  <= eba_q * ea_q;
      p_cdc_q  <= ecd_q * ec_q;
      p_dd_q   <= ed_q * ed_q;
      p_bb_q   <= eb_q * eb_q;
      p_dc_q   <= ed_q * ec_q;
      p_ba_q   <= eb_q * ea_q;
      p_cc_q   <= ec_q * ec_q;
      p_aa_q   <= ea_q * ea_q;

      tag3_q <= tag2_q;
      det_q  <= SUM_W'(p_ad_q) - SUM_W'(p_bc_q);
      n_q[0] <= SUM_W'(p_cdcd_q) + SUM_W'(p_baba_q);
      n_q[1] <= SUM_W'(p_cdd_q) - SUM_W'(p_bab_q);
      n_q[2] <= SUM_W'(p_baa_q) - SUM_W'(p_cdc_q);
      n_q[3] <= SUM_W'(p_dd_q) + SUM_W'(p_bb_q);
      n_q[4] <= -SUM_W'(p_dc_q) - SUM_W'(p_ba_q);
      n_q[5] <= SUM_W'(p_cc_q) + SUM_W'(p_aa_q);

      tag4_q  <= tag3_q;
      dmag_q  <= det_q[SUM_W-1] ? SUM_W'(-det_q) : SUM_W'(det_q);
      deg4_q  <= det_q == '0;
      area4_q <= area_rnd[SUM_W:FRAC_W+1];
      for (int i = 0; i < N_ENT; i++) begin
        nmag_q[i] <= n_q[i][SUM_W-1] ? SUM_W'(-n_q[i]) : SUM_W'(n_q[i]);
        neg4_q[i] <= n_q[i][SUM_W-1] ^ det_q[SUM_W-1];
      end

      tag5_q  <= tag4_q;
      den_q   <= {dmag_q[DEN_W-2:0], 1'b0};
      neg5_q  <= neg4_q;
      deg5_q  <= deg4_q;
      area5_q <= area4_q;
      for (int i = 0; i < N_ENT; i++) begin
        numer_q[i] <= (NUM_W'(nmag_q[i]) << FRAC_W) + NUM_W'(dmag_q);
      end

      tagd_q[0]  <= tag5_q;
      negd_q[0]  <= neg5_q;
      degd_q[0]  <= deg5_q;
      aread_q[0] <= area5_q;
      for (int i = 1; i < DIV_LAT; i++) begin
        tagd_q[i]  <= tagd_q[i-1];
        negd_q[i]  <= negd_q[i-1];
        degd_q[i]  <= degd_q[i-1];
        aread_q[i] <= aread_q[i-1];
      end

      out_q.tag_out    <= tagd_q[DIV_LAT-1];
      out_q.degenerate <= degd_q[DIV_LAT-1];
      out_q.k00        <= degd_q[DIV_LAT-1] ? '0 : ent[0];
      out_q.k01        <= degd_q[DIV_LAT-1] ? '0 : ent[1];
      out_q.k02        <= degd_q[DIV_LAT-1] ? '0 : ent[2];
      out_q.k11        <= degd_q[DIV_LAT-1] ? '0 : ent[3];
      out_q.k12        <= degd_q[DIV_LAT-1] ? '0 : ent[4];
      out_q.k22        <= degd_q[DIV_LAT-1] ? '0 : ent[5];
      out_q.area       <= OUT_W'($signed(aread_q[DIV_LAT-1]));
    end
  end

  for (genvar e = 0; e < N_ENT; e++) begin : g_ent
    p1ts_div u_div (
      .clk_i   (clk_i),
      .en_i    (adv),
      .numer_i (numer_q[e]),
      .den_i   (den_q),
      .q_o     (quo[e]),
      .ovf_o   (ovf[e])
    );
    assign ent[e] = sat_entry(ovf[e], negd_q[DIV_LAT-1][e], quo[e]);
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // degenerate triangles carry all-zero entries; checked on the diagonal and area
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.degenerate |->
      out_q.k00 == '0 && out_q.k11 == '0 && out_q.k22 == '0 && out_q.area == '0)
    else $error("degenerate result with nonzero entries");

  // diagonal entries follow the orientation given by a positive area
  a_diag_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.degenerate && !out_q.area[OUT_W-1] && out_q.area != '0 |->
      !out_q.k00[OUT_W-1] && !out_q.k11[OUT_W-1] && !out_q.k22[OUT_W-1])
    else $error("negative diagonal entry on anticlockwise triangle");

  // and a negative area gives no positive k00 or k22 entry
  a_diag_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.degenerate && out_q.area[OUT_W-1] |->
      (out_q.k00[OUT_W-1] || out_q.k00 == '0) && (out_q.k22[OUT_W-1] || out_q.k22 == '0))
    else $error("positive diagonal entry on clockwise triangle");

endmodule

### tb/sv/p1_triangle_stiffness_unit_tb.sv
`timescale 1ns / 1ps

module p1_triangle_stiffness_unit_tb;
  import p1ts_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 80;
  localparam logic signed [127:0] Q_HI = (128'sd1 <<< 47) - 128'sd1;
  localparam logic signed [127:0] Q_LO = -(128'sd1 <<< 47);

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  p1ts_in_if  in_if ();
  p1ts_out_if out_if ();

  p1_triangle_stiffness_unit u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always #1 clk = ~clk;

  out_t expected_q[$];
  int   n_mismatch = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   hold_cycles = 0;
  int   quiet_cycles = 0;
  bit   in_done_cyc;

  // ---------------- predictor ----------------
  function automatic logic signed [127:0] mul_exact(input longint p, input longint q);
    logic signed [127:0] wp, wq;
    wp = p;
    wq = q;
    return wp * wq;
  endfunction

  function automatic logic [OUT_W-1:0] clamp48(input logic signed [127:0] v);
    if (v > Q_HI) return ENT_MAX;
    if (v < Q_LO) return ENT_MIN;
    return v[OUT_W-1:0];
  endfunction

  // N / (2*det) in Q24.24, nearest, ties away from zero
  function automatic logic [OUT_W-1:0] scaled_entry(input logic signed [127:0] num,
                                                    input logic signed [127:0] det);
    logic [127:0] mn, md, q;
    logic         neg;
    neg = num[127] ^ det[127];
    mn  = num[127] ? -num : num;
    md  = det[127] ? -det : det;
    q   = ((mn << FRAC_W) + md) / (md << 1);
    return clamp48(neg ? -$signed(q) : $signed(q));
  endfunction

  function automatic out_t stiffness_of(input in_t t);
    out_t r;
    longint a, b, c, d, cd, ba;
    logic signed [127:0] det;
    a  = longint'(t.x1) - longint'(t.x0);
    b  = longint'(t.x2) - longint'(t.x0);
    c  = longint'(t.y1) - longint'(t.y0);
    d  = longint'(t.y2) - longint'(t.y0);
    cd = longint'(t.y1) - longint'(t.y2);
    ba = longint'(t.x2) - longint'(t.x1);
    det = mul_exact(a, d) - mul_exact(b, c);
    r = '0;
    r.tag_out = t.cell_tag;
    if (det == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    r.k00  = scaled_entry(mul_exact(cd, cd) + mul_exact(ba, ba), det);
    r.k01  = scaled_entry(mul_exact(cd, d) - mul_exact(ba, b), det);
    r.k02  = scaled_entry(mul_exact(ba, a) - mul_exact(cd, c), det);
    r.k11  = scaled_entry(mul_exact(d, d) + mul_exact(b, b), det);
    r.k12  = scaled_entry(-(mul_exact(d, c) + mul_exact(b, a)), det);
    r.k22  = scaled_entry(mul_exact(c, c) + mul_exact(a, a), det);
    r.area = clamp48((det + (128'sd1 <<< FRAC_W)) >>> (FRAC_W + 1));
    return r;
  endfunction

  // ---------------- driver ----------------
  task automatic send_triangle(input in_t t);
    bit ok;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= t;
    do begin
      @(negedge clk);
      ok = in_if.ready;
      @(posedge clk);
    end while (!ok);
    expected_q.push_back(stiffness_of(t));
  endtask

  task automatic idle_input();
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_t tri_of(input logic [31:0] tag,
                                 input int x0, input int y0, input int x1,
                                 input int y1, input int x2, input int y2);
    in_t t;
    t.cell_tag = tag;
    t.x0 = x0; t.y0 = y0; t.x1 = x1; t.y1 = y1; t.x2 = x2; t.y2 = y2;
    return t;
  endfunction

  function automatic int rand_coord(input int span_bits);
    if (span_bits >= 32) return int'($urandom);
    return int'($urandom_range((1 << span_bits) - 1)) - (1 << (span_bits - 1));
  endfunction

  function automatic in_t random_triangle();
    in_t t;
    int  sel, sb, k;
    sel = $urandom_range(99);
    sb  = (sel < 30) ? 32 : $urandom_range(26, 4);
    t = tri_of($urandom, rand_coord(sb), rand_coord(sb), rand_coord(sb),
               rand_coord(sb), rand_coord(sb), rand_coord(sb));
    if (sel >= 85) begin
      // collinear or coincident vertices
      k = $urandom_range(3) - 1;
      sb = $urandom_range(20, 2);
      t.x0 = rand_coord(sb); t.y0 = rand_coord(sb);
      t.x1 = rand_coord(sb); t.y1 = rand_coord(sb);
      t.x2 = t.x0 + k * (t.x1 - t.x0);
      t.y2 = t.y0 + k * (t.y1 - t.y0);
    end
    return t;
  endfunction

  // ---------------- receiver and checker ----------------
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(negedge clk) begin
    out_t exp_r, got;
    bit   bad;
    if (rst_n) begin
      in_done_cyc = in_if.valid && in_if.ready;
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (expected_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected result tag=%h", got.tag_out);
        end else begin
          exp_r = expected_q.pop_front();
          bad = (got.tag_out !== exp_r.tag_out) || (got.k00 !== exp_r.k00) ||
                (got.k01 !== exp_r.k01) || (got.k02 !== exp_r.k02) ||
                (got.k11 !== exp_r.k11) || (got.k12 !== exp_r.k12) ||
                (got.k22 !== exp_r.k22) || (got.area !== exp_r.area) ||
                (got.degenerate !== exp_r.degenerate);
          if (bad) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("mismatch exp tag=%h k=%h %h %h %h %h %h area=%h deg=%b",
                       exp_r.tag_out, exp_r.k00, exp_r.k01, exp_r.k02, exp_r.k11,
                       exp_r.k12, exp_r.k22, exp_r.area, exp_r.degenerate);
              $display("         got tag=%h k=%h %h %h %h %h %h area=%h deg=%b",
                       got.tag_out, got.k00, got.k01, got.k02, got.k11,
                       got.k12, got.k22, got.area, got.degenerate);
            end
          end
        end
        quiet_cycles = 0;
      end else if (in_done_cyc) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no request moved for %0d cycles", quiet_cycles);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_directed();
    send_idle_pct = 0; recv_stall_pct = 0;
    // unit right triangle, counter-clockwise then clockwise
    send_triangle(tri_of(32'h0, 0, 0, 1 << 24, 0, 0, 1 << 24));
    send_triangle(tri_of(32'hFFFF_FFFF, 0, 0, 0, 1 << 24, 1 << 24, 0));
    // all vertices equal, and collinear
    send_triangle(tri_of(32'h1, 0, 0, 0, 0, 0, 0));
    send_triangle(tri_of(32'h2, 5, 7, 10, 14, 15, 21));
    send_triangle(tri_of(32'h3, -2147483648, -2147483648, -2147483648,
                         -2147483648, -2147483648, -2147483648));
    // widest spans, all sign combinations of the extremes
    send_triangle(tri_of(32'h4, -2147483648, -2147483648, 2147483647,
                         -2147483648, -2147483648, 2147483647));
    send_triangle(tri_of(32'h5, 2147483647, 2147483647, -2147483648,
                         2147483647, 2147483647, -2147483648));
    send_triangle(tri_of(32'h6, -2147483648, 2147483647, 2147483647,
                         2147483647, -2147483648, -2147483648));
    // tiny determinants, with long edges first: those entries saturate both ways
    send_triangle(tri_of(32'h7, 0, 0, 2147483647, 0, 2147483647, 1));
    send_triangle(tri_of(32'h8, 0, 0, 2147483647, 1, 2147483647, 0));
    send_triangle(tri_of(32'h9, 0, 0, 1, 0, 0, 1));
    send_triangle(tri_of(32'hA, 0, 0, 0, 1, 1, 0));
    // area rounding at a quarter of the last place, both orientations
    send_triangle(tri_of(32'hB, 0, 0, 1, 0, 0, 1 << 23));
    send_triangle(tri_of(32'hC, 0, 0, 0, 1 << 23, 1, 0));
    send_triangle(tri_of(32'hAAAA_5555, 32'h5555_5555, 32'hAAAA_AAAA, -1, 1, 3, -7));
    idle_input();
  endtask

  task automatic test_random(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_triangle(random_triangle());
    idle_input();
  endtask

  // receiver holds off while requests keep coming, so the pipe fills and backs up
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 300;
    repeat (120) send_triangle(random_triangle());
    idle_input();
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(480, 0, 0);
    test_random(420, 83, 0);
    test_random(420, 0, 83);
    test_backpressure();
    test_random(420, 8, 8);
    test_random(60, 0, 0);

    recv_stall_pct = 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_mismatch == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/p1ts_pkg.sv
rtl/core/p1ts_if.sv
rtl/core/p1ts_div.sv
rtl/core/p1_triangle_stiffness_unit.sv
tb/sv/p1_triangle_stiffness_unit_tb.sv
